// ===== hdl/scc_pkg.sv =====
// shared types, constants and widths for the stick channel calibration block
package scc_pkg;

	localparam int CH_W             = 3;
	localparam int SAMPLE_W         = 12;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_W            = 49;
	localparam int NUM_CAL_REGS     = 6;
	localparam int NUM_CHANNELS_DEF = 6;

	localparam logic [SAMPLE_W-1:0] CENTRE = 12'd2048;
	localparam logic [SAMPLE_W-1:0] FULL   = 12'd4095;

	// centre scale is a power of two: the product becomes a shift
	localparam int CENTRE_SHIFT = 11;

	// serial divider geometry
	localparam int DIVIDEND_W = 24;
	localparam int DIGIT_W    = 2;
	localparam int DIV_STEPS  = DIVIDEND_W / DIGIT_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                rev;
		logic [SAMPLE_W-1:0] band;
		logic [SAMPLE_W-1:0] mid;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] lo;
	} cal_t;

	localparam cal_t CAL_RESET = cal_t'(49'd34376511488);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hdl/scc_divider.sv =====
// radix-4 restoring divider, two quotient bits per cycle
module scc_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [scc_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [scc_pkg::SAMPLE_W-1:0]    divisor,
	output scc_pkg::div_stat_t              stat,
	output logic [scc_pkg::DIVIDEND_W-1:0]  quotient
);
	import scc_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [SAMPLE_W-1:0]   rem_q;
	logic [SAMPLE_W-1:0]   div_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [SAMPLE_W-1:0]   rem_d;
	logic [DIVIDEND_W-1:0] quo_d;

	always_comb begin
		logic [SAMPLE_W:0] trial;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int k = 0; k < DIGIT_W; k++) begin
			trial = {rem_d, quo_d[DIVIDEND_W-1]};
			if (trial >= {1'b0, div_q}) begin
				rem_d = SAMPLE_W'(trial - {1'b0, div_q});
				quo_d = {quo_d[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_d = trial[SAMPLE_W-1:0];
				quo_d = {quo_d[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== hdl/scc_range.sv =====
// per-channel observed minimum and maximum tracking
module scc_range #(
	parameter int NUM_CHANNELS = scc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          update,
	input  logic [scc_pkg::CH_W-1:0]      channel,
	input  logic [scc_pkg::SAMPLE_W-1:0]  sample,
	output logic [scc_pkg::SAMPLE_W-1:0]  seen_min,
	output logic [scc_pkg::SAMPLE_W-1:0]  seen_max
);
	import scc_pkg::*;

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W:0] NUM_CH_L = (CH_W + 1)'(NUM_CHANNELS);

	logic [SAMPLE_W-1:0] low_q  [NUM_CHANNELS];
	logic [SAMPLE_W-1:0] high_q [NUM_CHANNELS];
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;

	logic [CH_IDX_W-1:0] idx;
	logic                chan_ok;
	logic [SAMPLE_W-1:0] new_low;
	logic [SAMPLE_W-1:0] new_high;

	assign idx     = chan_ok ? channel[CH_IDX_W-1:0] : '0;
	assign chan_ok = {1'b0, channel} < NUM_CH_L;
	assign new_low  = (sample < low_q[idx])  ? sample : low_q[idx];
	assign new_high = (sample > high_q[idx]) ? sample : high_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				low_q[i]  <= CENTRE;
				high_q[i] <= CENTRE;
			end
		end else if (update && chan_ok) begin
			low_q[idx]  <= new_low;
			high_q[idx] <= new_high;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			min_q <= chan_ok ? new_low  : '0;
			max_q <= chan_ok ? new_high : '0;
		end
	end

	assign seen_min = min_q;
	assign seen_max = max_q;

endmodule

// ===== hdl/stick_channel_calibration.sv =====
// stick channel calibration top level: config registers, sequencer and output register
//
// each accepted transaction carries one raw 12-bit stick sample and its channel
// number. on acceptance the channel's observed minimum and maximum are widened to
// include the sample; then the sample is mapped through the channel's calibration
// register (low end, high end, middle, dead band, reverse). inside the dead band
// the result is 2048; below or at the middle it is 2048 - (middle-sample)*2048/
// (middle-low), above it (sample-middle)*2048/(high-middle) + 2048, with signed
// quotients truncated toward zero, clamped to 0..4095 and mirrored when reverse is
// set. a zero divisor gives 0 below the middle and 4095 above it. a channel number
// at or beyond NUM_CHANNELS changes nothing and returns calibrated 2048 with zero
// minimum and maximum. one transaction is worked on at a time: the setup state picks
// the branch and starts the divider, the serial divider runs its twelve two-bit
// steps, the result is scaled, clamped and registered, and the hold state loads it
// into the output register once that is free. in_stall drops in the cycle after the
// load, so no new transaction is accepted before then. the next transaction is
// accepted even while the previous result waits on out_stall; a finished result then
// waits in the sequencer until the output register is free. the user must write
// calibration registers through cfg_write / cfg_index / cfg_data only while the
// block is idle; the block itself does not enforce this. indexes beyond the register
// list are ignored, and channels without a register keep the reset calibration
module stick_channel_calibration #(
	parameter int NUM_CHANNELS = scc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_write,
	input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scc_pkg::CFG_W-1:0]      cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [scc_pkg::CH_W-1:0]       channel,
	input  logic [scc_pkg::SAMPLE_W-1:0]   raw_sample,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [scc_pkg::CH_W-1:0]       out_channel,
	output logic [scc_pkg::SAMPLE_W-1:0]   calibrated,
	output logic [scc_pkg::SAMPLE_W-1:0]   seen_min,
	output logic [scc_pkg::SAMPLE_W-1:0]   seen_max
);
	import scc_pkg::*;

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W:0] NUM_CH_L = (CH_W + 1)'(NUM_CHANNELS);
	localparam int V_W = DIVIDEND_W + 2;
	localparam logic signed [V_W-1:0] CENTRE_V = $signed(V_W'(CENTRE));
	localparam logic signed [V_W-1:0] FULL_V   = $signed(V_W'(FULL));

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SETUP  = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_HOLD   = 4'b1000
	} state_t;

	state_t state_q;

	// calibration registers
	cal_t cal_q [NUM_CHANNELS];

	// transaction being worked on
	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                lower_q;
	logic                band_hit_q;
	logic                zero_q;
	logic                neg_q;
	logic                rev_q;
	logic                chan_ok_q;
	logic [SAMPLE_W-1:0] res_q;

	// output register
	logic                out_valid_q;
	logic [CH_W-1:0]     out_ch_q;
	logic [SAMPLE_W-1:0] out_cal_q;
	logic [SAMPLE_W-1:0] out_min_q;
	logic [SAMPLE_W-1:0] out_max_q;

	logic in_accept;
	logic out_free;
	logic out_load;

	// branch selection
	logic [CH_IDX_W-1:0]        ch_idx;
	cal_t                       cal_sel;
	logic                       lower;
	logic [SAMPLE_W-1:0]        offset;
	logic signed [SAMPLE_W:0]   div_s;
	logic                       div_neg;
	logic [SAMPLE_W-1:0]        div_mag;
	logic                       chan_ok;
	logic                       div_start;
	logic [DIVIDEND_W-1:0]      dividend;

	div_stat_t             div_stat;
	logic [DIVIDEND_W-1:0] quotient;

	logic [SAMPLE_W-1:0] seen_min_w;
	logic [SAMPLE_W-1:0] seen_max_w;
	logic [SAMPLE_W-1:0] res_d;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_HOLD) && out_free;
	assign div_start = (state_q == ST_SETUP);

	// config writes, out-of-range indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cal_q[i] <= CAL_RESET;
			end
		end else if (cfg_write && (cfg_index < CFG_IDX_W'(NUM_CAL_REGS))
				&& ({1'b0, cfg_index} < NUM_CH_L)) begin
			cal_q[cfg_index[CH_IDX_W-1:0]] <= cal_t'(cfg_data);
		end
	end

	// pick branch, distance and divisor for the latched sample
	assign chan_ok = {1'b0, ch_q} < NUM_CH_L;
	assign ch_idx  = chan_ok ? ch_q[CH_IDX_W-1:0] : '0;
	assign cal_sel = cal_q[ch_idx];
	assign lower   = sample_q <= cal_sel.mid;
	assign offset  = lower ? (cal_sel.mid - sample_q) : (sample_q - cal_sel.mid);
	assign div_s   = lower ? $signed({1'b0, cal_sel.mid} - {1'b0, cal_sel.lo})
	                       : $signed({1'b0, cal_sel.hi} - {1'b0, cal_sel.mid});
	assign div_neg = div_s[SAMPLE_W];
	assign div_mag = div_neg ? SAMPLE_W'(-div_s) : div_s[SAMPLE_W-1:0];
	assign dividend = DIVIDEND_W'({offset, {CENTRE_SHIFT{1'b0}}});

	scc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (div_mag),
		.stat     (div_stat),
		.quotient (quotient)
	);

	scc_range #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (in_accept),
		.channel  (channel),
		.sample   (raw_sample),
		.seen_min (seen_min_w),
		.seen_max (seen_max_w)
	);

	// scale around centre, clamp, mirror
	always_comb begin
		logic signed [V_W-1:0] q_v;
		logic signed [V_W-1:0] v;
		logic [SAMPLE_W-1:0]   c;
		q_v = $signed({2'b00, quotient});
		if (neg_q) begin
			q_v = -q_v;
		end
		v = lower_q ? (CENTRE_V - q_v) : (q_v + CENTRE_V);
		priority if (band_hit_q) begin
			c = CENTRE;
		end else if (zero_q) begin
			c = lower_q ? '0 : FULL;
		end else if (v < 0) begin
			c = '0;
		end else if (v > FULL_V) begin
			c = FULL;
		end else begin
			c = v[SAMPLE_W-1:0];
		end
		if (rev_q) begin
			c = FULL - c;
		end
		res_d = chan_ok_q ? c : CENTRE;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// transaction payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ch_q     <= channel;
			sample_q <= raw_sample;
		end
		if (state_q == ST_SETUP) begin
			lower_q    <= lower;
			band_hit_q <= offset < cal_sel.band;
			zero_q     <= (div_s == '0);
			neg_q      <= div_neg;
			rev_q      <= cal_sel.rev;
			chan_ok_q  <= chan_ok;
		end
		if ((state_q == ST_DIVIDE) && div_stat.done) begin
			res_q <= res_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// observed range is stable from acceptance until the load, and held here after
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q  <= ch_q;
			out_cal_q <= res_q;
			out_min_q <= seen_min_w;
			out_max_q <= seen_max_w;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign calibrated  = out_cal_q;
	assign seen_min    = out_min_q;
	assign seen_max    = out_max_q;

	// checks on the sequencing and result fields
	a_setup_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) |=> div_stat.busy)
		else $error("divider not busy after setup");

	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside divide state");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (seen_min <= seen_max))
		else $error("observed minimum above maximum");

	a_bad_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ({1'b0, out_channel} >= NUM_CH_L)) |->
		((calibrated == CENTRE) && (seen_min == '0) && (seen_max == '0)))
		else $error("out-of-range channel gave a calibrated result");

endmodule

// ===== tb/scc_checker.sv =====
// checker for the stick channel calibration block: predicts each result and compares
`timescale 1ns / 100ps

module scc_checker #(
	parameter int NUM_CHANNELS = scc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [scc_pkg::CH_W-1:0]      channel,
	input  logic [scc_pkg::SAMPLE_W-1:0]  raw_sample,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [scc_pkg::CH_W-1:0]      out_channel,
	input  logic [scc_pkg::SAMPLE_W-1:0]  calibrated,
	input  logic [scc_pkg::SAMPLE_W-1:0]  seen_min,
	input  logic [scc_pkg::SAMPLE_W-1:0]  seen_max,
	output int                            fail_count,
	output int                            pending
);
	import scc_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]     chan;
		logic [SAMPLE_W-1:0] position;
		logic [SAMPLE_W-1:0] low;
		logic [SAMPLE_W-1:0] high;
	} reading_t;

	cal_t                cal_copy[NUM_CHANNELS];
	logic [SAMPLE_W-1:0] low_seen[NUM_CHANNELS];
	logic [SAMPLE_W-1:0] high_seen[NUM_CHANNELS];
	reading_t            readings_due[$];

	// signed 64-bit arithmetic, quotients truncate toward zero
	function automatic logic [SAMPLE_W-1:0] calibrate_position(cal_t c,
			logic [SAMPLE_W-1:0] d);
		longint lo, hi, mid, band, s, offset, span, pos, ctr, full;
		lo = c.lo;
		hi = c.hi;
		mid = c.mid;
		band = c.band;
		ctr = CENTRE;
		full = FULL;
		s = d;
		offset = s - mid;
		if ((offset < 0 ? -offset : offset) < band) begin
			pos = ctr;
		end else if (s <= mid) begin
			span = mid - lo;
			pos = (span == 0) ? 0 : ctr - ((mid - s) * ctr) / span;
		end else begin
			span = hi - mid;
			pos = (span == 0) ? full : ((s - mid) * ctr) / span + ctr;
		end
		if (pos > full)
			pos = full;
		if (pos < 0)
			pos = 0;
		if (c.rev)
			pos = full - pos;
		return pos[SAMPLE_W-1:0];
	endfunction

	task automatic check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cal_copy[i] = CAL_RESET;
				low_seen[i] = CENTRE;
				high_seen[i] = CENTRE;
			end
			readings_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_write && cfg_index < NUM_CAL_REGS && cfg_index < NUM_CHANNELS)
				cal_copy[cfg_index] = cal_t'(cfg_data);

			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$display("%0t: result on channel %0d with no transaction outstanding",
						$time, out_channel);
					fail_count++;
				end else begin
					want = readings_due.pop_front();
					check_field("out_channel", want.chan, out_channel);
					check_field("calibrated", want.position, calibrated);
					check_field("seen_min", want.low, seen_min);
					check_field("seen_max", want.high, seen_max);
				end
			end

			if (in_valid && !in_stall) begin
				want.chan = channel;
				if (channel < NUM_CHANNELS) begin
					if (raw_sample < low_seen[channel])
						low_seen[channel] = raw_sample;
					if (raw_sample > high_seen[channel])
						high_seen[channel] = raw_sample;
					want.position = calibrate_position(cal_copy[channel], raw_sample);
					want.low = low_seen[channel];
					want.high = high_seen[channel];
				end else begin
					want.position = CENTRE;
					want.low = '0;
					want.high = '0;
				end
				readings_due.push_back(want);
			end
		end
		pending = readings_due.size();
	end

endmodule

// ===== tb/tb_stick_channel_calibration.sv =====
// testbench top for the stick channel calibration block: stimulus, receiver and verdict
`timescale 1ns / 100ps

module tb_stick_channel_calibration;
	import scc_pkg::*;

	localparam int PHASES          = 8;
	localparam int PHASE_READINGS  = 135;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam int TOP_CHANNEL     = (1 << CH_W) - 1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CH_W-1:0]      channel = '0;
	logic [SAMPLE_W-1:0]  raw_sample = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CH_W-1:0]      out_channel;
	logic [SAMPLE_W-1:0]  calibrated;
	logic [SAMPLE_W-1:0]  seen_min;
	logic [SAMPLE_W-1:0]  seen_max;

	int fail_count;
	int pending;

	// calm: no gaps on either side; hold_req: set once by the sender, receiver
	// answers with one long hold-off
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	// calibration the block holds now, and the set the next phase loads
	cal_t cal_now[NUM_CAL_REGS];
	cal_t cal_next[NUM_CAL_REGS];

	stick_channel_calibration dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.channel     (channel),
		.raw_sample  (raw_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.calibrated  (calibrated),
		.seen_min    (seen_min),
		.seen_max    (seen_max)
	);

	scc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.channel     (channel),
		.raw_sample  (raw_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_channel (out_channel),
		.calibrated  (calibrated),
		.seen_min    (seen_min),
		.seen_max    (seen_max),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#8_000_000;
		$display("stick_channel_calibration verification failed");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic cal_t pack_cal(logic rev, logic [SAMPLE_W-1:0] band,
			logic [SAMPLE_W-1:0] mid, logic [SAMPLE_W-1:0] hi, logic [SAMPLE_W-1:0] lo);
		return {rev, band, mid, hi, lo};
	endfunction

	// mix of sane stick setups, raw random words and all-or-nothing fields
	function automatic cal_t random_cal();
		logic [63:0]         word;
		logic [SAMPLE_W-1:0] mid, lo, hi, band;
		int                  kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			return pack_cal(1'($urandom_range(0, 1)),
				$urandom_range(0, 1) ? FULL : '0, $urandom_range(0, 1) ? FULL : '0,
				$urandom_range(0, 1) ? FULL : '0, $urandom_range(0, 1) ? FULL : '0);
		end
		if (kind < 3) begin
			word = {$urandom, $urandom};
			return word[CFG_W-1:0];
		end
		mid = SAMPLE_W'($urandom_range(200, 3900));
		// now and then let an end sit on the middle so a divisor is zero
		lo = ($urandom_range(0, 7) == 0) ? mid : SAMPLE_W'($urandom_range(0, mid - 1));
		hi = ($urandom_range(0, 7) == 0) ? mid : SAMPLE_W'($urandom_range(mid + 1, FULL));
		band = ($urandom_range(0, 2) == 0) ? '0 : SAMPLE_W'($urandom_range(0, 400));
		return pack_cal(1'($urandom_range(0, 1)), band, mid, hi, lo);
	endfunction

	function automatic logic [CH_W-1:0] pick_channel();
		if ($urandom_range(0, 9) == 0)
			return CH_W'($urandom_range(NUM_CHANNELS_DEF, TOP_CHANNEL));
		return CH_W'($urandom_range(0, NUM_CHANNELS_DEF - 1));
	endfunction

	// uniform, rail values, or clustered around the channel's middle and dead band
	function automatic logic [SAMPLE_W-1:0] pick_sample(logic [CH_W-1:0] ch);
		int r, v;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? FULL : '0;
		if (r < 4 && ch < NUM_CAL_REGS) begin
			v = $urandom_range(0, 1000);
			v = v - 500 + cal_now[ch].mid;
			if (v < 0)
				v = 0;
			if (v > FULL)
				v = FULL;
			return SAMPLE_W'(v);
		end
		return SAMPLE_W'($urandom_range(0, FULL));
	endfunction

	// offer one transaction and return at the edge that takes it; valid stays up
	// so a back-to-back transaction never drops and raises it in one step
	task automatic send_reading(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] sample);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		raw_sample <= sample;
		do @(posedge clk); while (in_stall);
	endtask

	// sender pauses until every expected result has come back; the checker's count first
	// catches up, so it already holds a transaction taken at the edge just passed
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// block is idle once drained; then load all six registers
	// plus one write to an index past the list, which must be ignored
	task automatic program_calibration();
		logic [63:0] word;
		drain();
		repeat (4) @(posedge clk);
		for (int i = 0; i < NUM_CAL_REGS; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= cal_next[i];
			cal_now[i] = cal_next[i];
			@(posedge clk);
		end
		word = {$urandom, $urandom};
		cfg_index <= CFG_IDX_W'($urandom_range(NUM_CAL_REGS, (1 << CFG_IDX_W) - 1));
		cfg_data <= word[CFG_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// receiver: stall stretches of random length, and one long hold-off on request
	initial begin
		int n;
		bit held;
		held = 1'b0;
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		for (int i = 0; i < NUM_CAL_REGS; i++)
			cal_now[i] = CAL_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: rails, the middle itself, either side of it,
		// and both channel numbers past the last channel
		send_reading(0, 0);
		send_reading(0, FULL);
		send_reading(0, CENTRE);
		send_reading(1, SAMPLE_W'(CENTRE - 1));
		send_reading(1, SAMPLE_W'(CENTRE + 1));
		send_reading(5, FULL);
		send_reading(CH_W'(NUM_CHANNELS_DEF), 1234);
		send_reading(CH_W'(TOP_CHANNEL), FULL);
		send_reading(CH_W'(TOP_CHANNEL), 0);

		// hand-built setups, one corner per channel
		cal_next[0] = pack_cal(1'b0, 300, 2000, 4000, 100);   // wide dead band
		cal_next[1] = pack_cal(1'b0, 0, 1500, 3500, 1500);    // low end on the middle
		cal_next[2] = pack_cal(1'b1, 0, 2500, 2500, 500);     // high end on the middle, mirrored
		cal_next[3] = pack_cal(1'b0, 0, 1000, 200, 3000);     // ends swapped
		cal_next[4] = pack_cal(1'b0, 0, 0, 0, 0);             // all fields zero
		cal_next[5] = pack_cal(1'b1, FULL, FULL, FULL, FULL); // all fields full
		program_calibration();

		// dead band: on the middle, just inside, exactly on the edge
		send_reading(0, 2000);
		send_reading(0, 1750);
		send_reading(0, 1700);
		// zero low divisor: at the middle and below gives 0, above scales normally
		send_reading(1, 1500);
		send_reading(1, 1000);
		send_reading(1, 3000);
		// middle takes the lower branch; above it the zero divisor saturates
		send_reading(2, 2500);
		send_reading(2, 2600);
		// swapped ends: negative quotients pushed through the clamp
		send_reading(3, 500);
		send_reading(3, 2000);
		send_reading(3, 0);
		send_reading(4, 0);
		send_reading(4, 1);
		send_reading(5, 0);
		send_reading(5, FULL);
		send_reading(5, 2000);

		// random phases, each with a fresh calibration set
		for (int phase = 0; phase < PHASES; phase++) begin
			for (int i = 0; i < NUM_CAL_REGS; i++)
				cal_next[i] = random_cal();
			program_calibration();
			calm = (phase == 5);
			// receiver holds off while transactions keep coming, so input backs up
			if (phase == 3)
				hold_req = 1'b1;
			repeat (PHASE_READINGS) begin
				logic [CH_W-1:0] ch;
				ch = pick_channel();
				send_reading(ch, pick_sample(ch));
			end
		end
		calm = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("stick_channel_calibration verification clean");
		else
			$display("stick_channel_calibration verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/scc_pkg.sv
hdl/scc_divider.sv
hdl/scc_range.sv
hdl/stick_channel_calibration.sv
tb/scc_checker.sv
tb/tb_stick_channel_calibration.sv
